@@ rtl/core/lcd_panel_bit_serializer_top_defines.svh @@
// Assertion macros used by the checker file.
// Each expands to one labeled concurrent assertion, clocked on clk and
// disabled while arst_n is low.
`ifndef LCD_PANEL_BIT_SERIALIZER_TOP_DEFINES_SVH
`define LCD_PANEL_BIT_SERIALIZER_TOP_DEFINES_SVH

// same-cycle implication
`define LPBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPBS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/lpbs_pkg.sv @@
`default_nettype none
package lpbs_pkg;

	localparam int unsigned COL_W = 9;
	localparam int unsigned REP_W = 5;
	localparam int unsigned PAD_W = 6;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned BIT_IDX_W = $clog2(BYTE_W);

	// line geometry, in data columns
	localparam logic [COL_W-1:0] TOP_LINE_BITS = COL_W'(6 * 12);
	localparam logic [COL_W-1:0] BOT_MARK_A    = COL_W'(4 * 11);
	localparam logic [COL_W-1:0] BOT_MARK_B    = COL_W'(4 * 11 + 10 * 11);
	localparam logic [COL_W-1:0] BOT_LINE_BITS = COL_W'(4 * 11 + 10 * 11 + 10 * 11);

	// padding run lengths
	localparam logic [PAD_W-1:0] TOP_PAD_EDGE  = PAD_W'(4);
	localparam logic [PAD_W-1:0] BOT_PAD_START = PAD_W'(36);
	localparam logic [PAD_W-1:0] BOT_PAD_MID_A = PAD_W'(5);
	localparam logic [PAD_W-1:0] BOT_PAD_MID_B = PAD_W'(10);
	localparam logic [PAD_W-1:0] BOT_PAD_END   = PAD_W'(5);

	// lines per chain before swapping
	localparam logic [REP_W-1:0] TOP_REP_LONG  = REP_W'(16);
	localparam logic [REP_W-1:0] TOP_REP_SHORT = REP_W'(8);
	localparam logic [REP_W-1:0] BOT_REP_LONG  = REP_W'(4);
	localparam logic [REP_W-1:0] BOT_REP_SHORT = REP_W'(2);

	typedef struct packed {
		logic load;
		logic adv;
	} sh_ctl_t;

	typedef struct packed {
		logic bit_val;
		logic final_bit;
	} sh_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/lcd_panel_bit_serializer_top.sv @@
// The first pulse of an item passes the sequencer state register and then the output register
// after the item is accepted. One pulse per cycle while the receiver does not stall; an item
// is accepted only while the single pulse sequencer is idle, so it handles one item at a time.
// Reset: arst_n clears row, column, repeat count and chain select (top first) and empties
// the output register; a row write clears the same counters.
`default_nettype none
module lcd_panel_bit_serializer_top
	import lpbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	// config: row number register
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        row_number,

	// pixel byte in
	input  logic              pix_valid,
	output logic              pix_stall,
	input  logic [BYTE_W-1:0] pixel_byte,

	// panel pulses out
	output logic              pulse_valid,
	input  logic              pulse_stall,
	output logic              chain_select,
	output logic              data_bit,
	output logic              last
);

	sh_ctl_t sh_ctl;
	sh_sts_t sh_sts;

	logic busy;
	logic start;
	logic go;
	logic emit;
	logic chain;
	logic dbit;
	logic last_d;
	logic cfg_wr;

	logic out_valid_q;
	logic chain_q;
	logic dbit_q;
	logic last_q;

	// one item in flight; stall input for the whole item
	assign pix_stall = busy;
	assign start     = pix_valid && !busy;

	// row write only when no item is in flight or being offered,
	// so it never lands mid-item or races an accept
	assign cfg_ready = !busy && !pix_valid;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// output register advances when empty or being drained
	assign go = !out_valid_q || !pulse_stall;

	lpbs_shifter u_shifter (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_byte (pixel_byte),
		.ctl        (sh_ctl),
		.sts        (sh_sts)
	);

	lpbs_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.go      (go),
		.cfg_wr  (cfg_wr),
		.cfg_row (row_number),
		.sh_sts  (sh_sts),
		.sh_ctl  (sh_ctl),
		.busy    (busy),
		.emit    (emit),
		.chain   (chain),
		.dbit    (dbit),
		.last    (last_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= emit;
		end
	end

	// pulse payload, held while stalled
	always_ff @(posedge clk) begin
		if (emit) begin
			chain_q <= chain;
			dbit_q  <= dbit;
			last_q  <= last_d;
		end
	end

	assign pulse_valid  = out_valid_q;
	assign chain_select = chain_q;
	assign data_bit     = dbit_q;
	assign last         = last_q;

endmodule
`default_nettype wire

@@ rtl/core/lpbs_shifter.sv @@
`default_nettype none
module lpbs_shifter
	import lpbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] pixel_byte,
	input  sh_ctl_t           ctl,
	output sh_sts_t           sts
);

	logic [BYTE_W-1:0]    sh_q;
	logic [BIT_IDX_W-1:0] idx_q;

	// byte shift register, LSB out first
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sh_q <= pixel_byte;
		end else if (ctl.adv) begin
			sh_q <= sh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.load) begin
			idx_q <= '0;
		end else if (ctl.adv) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign sts.bit_val   = sh_q[0];
	assign sts.final_bit = &idx_q;

endmodule
`default_nettype wire

@@ rtl/core/lpbs_seq.sv @@
`default_nettype none
module lpbs_seq
	import lpbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        go,
	input  logic        cfg_wr,
	input  logic [7:0]  cfg_row,
	input  sh_sts_t     sh_sts,
	output sh_ctl_t     sh_ctl,
	output logic        busy,
	output logic        emit,
	output logic        chain,
	output logic        dbit,
	output logic        last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BIT  = 2'd1;
	localparam logic [1:0] ST_POST = 2'd2;

	logic [1:0]       state_q;
	logic [PAD_W-1:0] pad_q;
	logic [COL_W-1:0] col_q;
	logic [REP_W-1:0] rep_q;
	logic             bottom_q;
	logic [7:0]       row_q;

	logic [PAD_W-1:0] pre_len;
	logic [PAD_W-1:0] post_len;
	logic [COL_W-1:0] col_inc;
	logic [REP_W-1:0] rep_inc;
	logic [REP_W-1:0] limit;
	logic             pre_done;
	logic             post_done;
	logic             line_end;
	logic             short_row;
	logic             swap;

	// leading padding owed before the data bit at this column
	function automatic logic [PAD_W-1:0] pre_pad_len(input logic bot, input logic [COL_W-1:0] col);
		logic [PAD_W-1:0] n;
		n = '0;
		if (bot) begin
			if (col == '0) begin
				n = BOT_PAD_START;
			end else if (col == BOT_MARK_A) begin
				n = BOT_PAD_MID_A;
			end else if (col == BOT_MARK_B) begin
				n = BOT_PAD_MID_B;
			end
		end else if (col == '0) begin
			n = TOP_PAD_EDGE;
		end
		return n;
	endfunction

	assign pre_len   = pre_pad_len(bottom_q, col_q);
	assign pre_done  = pad_q == pre_len;
	assign post_len  = bottom_q ? BOT_PAD_END : TOP_PAD_EDGE;
	assign post_done = (pad_q + 1'b1) == post_len;
	assign col_inc   = col_q + 1'b1;
	assign line_end  = bottom_q ? (col_inc == BOT_LINE_BITS) : (col_inc == TOP_LINE_BITS);
	assign short_row = row_q[7:1] == '0;
	assign limit     = bottom_q ? (short_row ? BOT_REP_LONG : BOT_REP_SHORT)
	                            : (short_row ? TOP_REP_LONG : TOP_REP_SHORT);
	assign rep_inc   = rep_q + 1'b1;
	assign swap      = rep_inc == limit;

	assign busy  = state_q != ST_IDLE;
	assign emit  = busy && go;
	assign chain = bottom_q;

	always_comb begin
		sh_ctl = '{load: start, adv: 1'b0};
		dbit   = 1'b0;
		last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_BIT: begin
				dbit = pre_done && sh_sts.bit_val;
				if (pre_done && !line_end) begin
					last       = sh_sts.final_bit;
					sh_ctl.adv = go;
				end
			end
			ST_POST: begin
				if (post_done) begin
					last       = sh_sts.final_bit;
					sh_ctl.adv = go;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pad_q    <= '0;
			col_q    <= '0;
			rep_q    <= '0;
			bottom_q <= 1'b0;
			row_q    <= '0;
		end else if (cfg_wr) begin
			row_q    <= cfg_row;
			col_q    <= '0;
			rep_q    <= '0;
			bottom_q <= 1'b0;
		end else if (start) begin
			state_q <= ST_BIT;
			pad_q   <= '0;
		end else if (emit) begin
			unique case (state_q)
				ST_BIT: begin
					if (!pre_done) begin
						pad_q <= pad_q + 1'b1;
					end else if (line_end) begin
						col_q   <= '0;
						pad_q   <= '0;
						state_q <= ST_POST;
					end else begin
						col_q   <= col_inc;
						pad_q   <= '0;
						state_q <= sh_sts.final_bit ? ST_IDLE : ST_BIT;
					end
				end
				ST_POST: begin
					if (post_done) begin
						// line finished: count it, swap chains at the limit
						rep_q    <= swap ? '0 : rep_inc;
						bottom_q <= bottom_q ^ swap;
						pad_q    <= '0;
						state_q  <= sh_sts.final_bit ? ST_IDLE : ST_BIT;
					end else begin
						pad_q <= pad_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/lpbs_checker.sv @@
`default_nettype none
`include "lcd_panel_bit_serializer_top_defines.svh"
module lpbs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pix_valid,
	input wire logic pix_stall,
	input wire logic pulse_valid,
	input wire logic pulse_stall,
	input wire logic chain_select,
	input wire logic data_bit,
	input wire logic last
);

	// a stalled pulse keeps its payload
	`LPBS_ASSERT_NXT(a_out_hold, pulse_valid && pulse_stall, pulse_valid && $stable({chain_select, data_bit, last}), "stalled pulse changed")

	// an accepted byte holds off the next one
	`LPBS_ASSERT_NXT(a_busy_after_accept, pix_valid && !pix_stall, pix_stall, "input open right after accept")

	// the input stays closed until the final pulse of the byte is produced
	`LPBS_ASSERT_NOW(a_busy_mid_item, pulse_valid && !last, pix_stall, "input open before final pulse")

	// busy only starts from an accepted byte
	`LPBS_ASSERT_NOW(a_busy_from_accept, $rose(pix_stall), $past(pix_valid), "stall rose without an item")

endmodule

bind lcd_panel_bit_serializer_top lpbs_checker u_lpbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pix_valid    (pix_valid),
	.pix_stall    (pix_stall),
	.pulse_valid  (pulse_valid),
	.pulse_stall  (pulse_stall),
	.chain_select (chain_select),
	.data_bit     (data_bit),
	.last         (last)
);
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import lpbs_pkg::*;

	// Line geometry and padding of the two panel chains, in pulses.
	localparam int TOP_COLS      = 72;
	localparam int BOT_COLS      = 264;
	localparam int BOT_SPLIT_A   = 44;
	localparam int BOT_SPLIT_B   = 154;
	localparam int TOP_EDGE_PADS = 4;
	localparam int BOT_LEAD_PADS = 36;
	localparam int BOT_A_PADS    = 5;
	localparam int BOT_B_PADS    = 10;
	localparam int BOT_TAIL_PADS = 5;

	// Lines per chain before the swap; rows 0 and 1 get the long counts.
	localparam int TOP_LINES_LONG  = 16;
	localparam int TOP_LINES_SHORT = 8;
	localparam int BOT_LINES_LONG  = 4;
	localparam int BOT_LINES_SHORT = 2;

	// Cycles allowed after the last expected pulse before the block counts as idle.
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic chain;
		logic level;
		logic fin;
	} pulse_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [7:0]        row_number;
	logic              pix_valid;
	logic              pix_stall;
	logic [BYTE_W-1:0] pixel_byte;
	logic              pulse_valid;
	logic              pulse_stall;
	logic              chain_select;
	logic              data_bit;
	logic              last;

	// Predictor state: a copy of the block's row register and counters.
	logic [7:0] row_sel;
	logic [8:0] col_cnt;
	logic [4:0] line_cnt;
	logic       on_bottom;

	// Pulses still owed by the block, oldest first.
	pulse_t pending_pulses[$];

	int err_cnt = 0;
	int pulse_seen = 0;
	// While set, neither side inserts gaps or stalls.
	bit calm;

	lcd_panel_bit_serializer_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.row_number  (row_number),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pixel_byte  (pixel_byte),
		.pulse_valid (pulse_valid),
		.pulse_stall (pulse_stall),
		.chain_select(chain_select),
		.data_bit    (data_bit),
		.last        (last)
	);

	always #4 clk = ~clk;

	// Hard stop in case the block hangs or owes pulses it never sends.
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver back-pressure: random stalls, each drawn with an 11 percent chance.
	always @(posedge clk) begin
		pulse_stall <= !calm && ($urandom_range(99) < 11);
	end

	task automatic note_mismatch(input string what);
		err_cnt++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Expands one accepted byte into the pulses the panel should see, and
	// advances the line/repeat counters exactly as the block should.
	function automatic void expand_byte(input logic [BYTE_W-1:0] b);
		pulse_t run[$];
		pulse_t p;
		int lead;
		int lines_max;
		for (int i = 0; i < BYTE_W; i++) begin
			// padding that comes before this column
			lead = 0;
			if (!on_bottom) begin
				if (col_cnt == 0)
					lead = TOP_EDGE_PADS;
			end else if (col_cnt == 0) begin
				lead = BOT_LEAD_PADS;
			end else if (col_cnt == BOT_SPLIT_A) begin
				lead = BOT_A_PADS;
			end else if (col_cnt == BOT_SPLIT_B) begin
				lead = BOT_B_PADS;
			end
			repeat (lead) run.push_back('{on_bottom, 1'b0, 1'b0});
			run.push_back('{on_bottom, b[i], 1'b0});
			col_cnt = col_cnt + 9'd1;
			// end of line: tail padding, then repeat count and maybe a chain swap
			if (col_cnt == (on_bottom ? BOT_COLS : TOP_COLS)) begin
				repeat (on_bottom ? BOT_TAIL_PADS : TOP_EDGE_PADS)
					run.push_back('{on_bottom, 1'b0, 1'b0});
				col_cnt = '0;
				if (on_bottom)
					lines_max = (row_sel < 2) ? BOT_LINES_LONG : BOT_LINES_SHORT;
				else
					lines_max = (row_sel < 2) ? TOP_LINES_LONG : TOP_LINES_SHORT;
				line_cnt = line_cnt + 5'd1;
				if (line_cnt == lines_max) begin
					line_cnt = '0;
					on_bottom = !on_bottom;
				end
			end
		end
		// the final pulse of the byte carries the last marker
		foreach (run[j]) begin
			p = run[j];
			p.fin = (j == run.size() - 1);
			pending_pulses.push_back(p);
		end
	endfunction

	// Offers one byte; valid stays high afterwards so back-to-back items need
	// no drop. A random gap, when taken, lowers valid first.
	task automatic send_pixel(input logic [BYTE_W-1:0] b);
		if (!calm) begin
			while ($urandom_range(99) < 11) begin
				pix_valid <= 1'b0;
				@(posedge clk);
			end
		end
		pix_valid  <= 1'b1;
		pixel_byte <= b;
		do @(posedge clk); while (pix_stall);
		expand_byte(b);
	endtask

	// Closes a burst; only ever called after an accept, so one drive per step.
	task automatic end_burst();
		pix_valid <= 1'b0;
	endtask

	// Waits for the block to drain, then writes the row register.
	task automatic write_row(input logic [7:0] v);
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid  <= 1'b1;
		row_number <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		// a row write also restarts the line on the top chain
		row_sel   = v;
		col_cnt   = '0;
		line_cnt  = '0;
		on_bottom = 1'b0;
	endtask

	// Compares every accepted pulse with the oldest one owed.
	always @(posedge clk) begin
		pulse_t want;
		if (arst_n && pulse_valid && !pulse_stall) begin
			pulse_seen++;
			if (pending_pulses.size() == 0) begin
				note_mismatch($sformatf("pulse %0d arrived with none expected", pulse_seen));
			end else begin
				want = pending_pulses.pop_front();
				if (chain_select !== want.chain)
					note_mismatch($sformatf("pulse %0d chain_select %b, want %b",
						pulse_seen, chain_select, want.chain));
				if (data_bit !== want.level)
					note_mismatch($sformatf("pulse %0d data_bit %b, want %b",
						pulse_seen, data_bit, want.level));
				if (last !== want.fin)
					note_mismatch($sformatf("pulse %0d last %b, want %b",
						pulse_seen, last, want.fin));
			end
		end
	end

	// Default row after reset, byte extremes and single-bit positions.
	task automatic test_power_on_row();
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h01);
		send_pixel(8'h80);
		end_burst();
	endtask

	// Row extremes and the long/short boundary; each write lands mid-line and
	// must clear the counters.
	task automatic test_row_extremes();
		write_row(8'd255);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		send_pixel(8'h0F);
		end_burst();
		write_row(8'd0);
		send_pixel(8'hF0);
		send_pixel(8'h3C);
		end_burst();
		write_row(8'd1);
		send_pixel(8'hC3);
		send_pixel(8'h7E);
		end_burst();
	endtask

	// One whole top line plus a byte: tail padding, then lead padding of the next line.
	task automatic test_top_line_wrap();
		write_row(8'd3);
		for (int i = 0; i < 10; i++)
			send_pixel((i % 2) ? 8'hFF : 8'h81);
		end_burst();
	endtask

	// Short repeat counts: 8 top lines, 2 bottom lines, then back on top.
	// The opening stretch runs with no gaps or stalls.
	task automatic test_short_swap_cycle();
		write_row(8'd2);
		calm = 1'b1;
		for (int i = 0; i < 140; i++) begin
			if (i == 40)
				calm = 1'b0;
			send_pixel(BYTE_W'($urandom));
		end
		end_burst();
	endtask

	// Long repeat counts: 16 top lines before the first bottom lines.
	task automatic test_long_swap_cycle();
		write_row(8'd1);
		for (int i = 0; i < 145; i++)
			send_pixel(BYTE_W'($urandom_range(255)));
		end_burst();
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		row_number  = '0;
		pix_valid   = 1'b0;
		pixel_byte  = '0;
		calm        = 1'b0;
		row_sel     = '0;
		col_cnt     = '0;
		line_cnt    = '0;
		on_bottom   = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_row();
		test_row_extremes();
		test_top_line_wrap();
		test_short_swap_cycle();
		test_long_swap_cycle();

		// drain, then give stray pulses a chance to show up
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);

		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
